// ===== src/tcgr_pkg.sv =====
// shared types, constants and color functions of the text cell glyph renderer
`default_nettype none

package tcgr_pkg;

	// font word width and command queue depth
	localparam int unsigned FONT_W      = 16;
	localparam int unsigned QUEUE_DEPTH = 2;

	// item function codes
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_DRAW = 1'b1;

	// monochrome attribute classes and gray levels
	localparam logic [7:0] MDA_CLASS_MASK = 8'h77;
	localparam logic [7:0] MDA_REVERSE    = 8'h70;
	localparam logic [7:0] GRAY_BLACK     = 8'h00;
	localparam logic [7:0] GRAY_DARK      = 8'h3F;
	localparam logic [7:0] GRAY_NORMAL    = 8'h9F;
	localparam logic [7:0] GRAY_BRIGHT    = 8'hFF;

	// attribute bit positions
	localparam int unsigned ATTR_INTENSE = 3;
	localparam int unsigned ATTR_BG_HI   = 7;

	localparam logic [7:0] MASK_ALL = 8'hFF;

	typedef logic [23:0] rgb_t;

	typedef struct packed {
		rgb_t fg;
		rgb_t bg;
	} colors_t;

	// one classified item travelling from front to back
	typedef struct packed {
		logic        is_draw;
		logic [7:0]  glyph;
		logic [3:0]  frow;
		logic [15:0] word;
		rgb_t        fg;
		rgb_t        bg;
		logic        overlay;
	} cmd_t;

	// 16 entry color palette
	function automatic rgb_t ega_color(input logic [3:0] idx);
		rgb_t c;
		unique case (idx)
			4'd0:  c = 24'h000000;
			4'd1:  c = 24'h0000C0;
			4'd2:  c = 24'h00C000;
			4'd3:  c = 24'h00C0C0;
			4'd4:  c = 24'hC00000;
			4'd5:  c = 24'hC000C0;
			4'd6:  c = 24'hC08000;
			4'd7:  c = 24'hC0C0C0;
			4'd8:  c = 24'h808080;
			4'd9:  c = 24'h0000FF;
			4'd10: c = 24'h00FF00;
			4'd11: c = 24'h00FFFF;
			4'd12: c = 24'hFF0000;
			4'd13: c = 24'hFF00FF;
			4'd14: c = 24'hFFFF00;
			4'd15: c = 24'hFFFFFF;
		endcase
		return c;
	endfunction

	function automatic rgb_t gray(input logic [7:0] lv);
		return {lv, lv, lv};
	endfunction

	// foreground and background of an attribute byte
	function automatic colors_t cell_colors(input logic mono, input logic [7:0] attr);
		colors_t    c;
		logic [7:0] cls;
		logic [7:0] f;
		logic [7:0] b;
		cls = attr & MDA_CLASS_MASK;
		f   = GRAY_BLACK;
		b   = GRAY_BLACK;
		if (mono) begin
			priority if (cls == 8'h00) begin
				f = GRAY_BLACK;
				b = GRAY_BLACK;
			end else if (cls == MDA_REVERSE) begin
				f = attr[ATTR_INTENSE] ? GRAY_DARK : GRAY_BLACK;
				b = attr[ATTR_BG_HI] ? GRAY_BRIGHT : GRAY_NORMAL;
			end else begin
				f = attr[ATTR_INTENSE] ? GRAY_BRIGHT : GRAY_NORMAL;
				b = GRAY_BLACK;
			end
			c.fg = gray(f);
			c.bg = gray(b);
		end else begin
			c.fg = ega_color(attr[3:0]);
			c.bg = ega_color({1'b0, attr[6:4]});
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== src/tcgr_if.sv =====
// item channel interfaces of the text cell glyph renderer
`default_nettype none

interface tcgr_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [7:0]  char_code;
	logic [3:0]  font_row;
	logic [15:0] font_word;
	logic [7:0]  attr;
	logic        overlay;

	modport source (output valid, func, char_code, font_row, font_word, attr, overlay,
		input ready);
	modport sink (input valid, func, char_code, font_row, font_word, attr, overlay,
		output ready);
endinterface

interface tcgr_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  row;
	logic [7:0]  pixel_bits;
	logic [7:0]  write_mask;
	logic [23:0] fg_rgb;
	logic [23:0] bg_rgb;
	logic        last;

	modport source (output valid, row, pixel_bits, write_mask, fg_rgb, bg_rgb, last,
		input ready);
	modport sink (input valid, row, pixel_bits, write_mask, fg_rgb, bg_rgb, last,
		output ready);
endinterface

`default_nettype wire

// ===== src/tcgr_front.sv =====
// front end: mode register, item classification and color lookup
`default_nettype none

module tcgr_front import tcgr_pkg::*; #(
	parameter int unsigned GLYPH_ROWS  = 16,
	parameter int unsigned GLYPH_COUNT = 256
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_we,
	input  wire logic  cfg_wdata,
	tcgr_in_if.sink    cell_in,
	output logic       push_valid,
	input  wire logic  push_ready,
	output cmd_t       push_cmd,
	output logic       mono_mode
);

	logic       mono_q;
	logic [7:0] glyph;
	logic       keep;
	colors_t    colors;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mono_q <= 1'b0;
		end else if (cfg_we) begin
			mono_q <= cfg_wdata;
		end
	end

	assign mono_mode = mono_q;

	// glyph number wraps once at the glyph count
	always_comb begin
		if ({1'b0, cell_in.char_code} >= 9'(GLYPH_COUNT)) begin
			glyph = 8'({1'b0, cell_in.char_code} - 9'(GLYPH_COUNT));
		end else begin
			glyph = cell_in.char_code;
		end
	end

	// loads to rows beyond the glyph height are dropped
	assign keep = (cell_in.func == FUNC_DRAW) ||
		({2'b00, cell_in.font_row} < 6'(GLYPH_ROWS));

	assign colors = cell_colors(mono_q, cell_in.attr);

	// classified item into the queue
	always_comb begin
		push_cmd.is_draw = (cell_in.func == FUNC_DRAW);
		push_cmd.glyph   = glyph;
		push_cmd.frow    = cell_in.font_row;
		push_cmd.word    = cell_in.font_word;
		push_cmd.fg      = colors.fg;
		push_cmd.bg      = colors.bg;
		push_cmd.overlay = cell_in.overlay;
	end

	assign push_valid    = cell_in.valid && keep;
	assign cell_in.ready = push_ready;

endmodule

`default_nettype wire

// ===== src/tcgr_queue.sv =====
// short command queue between front and back
`default_nettype none

module tcgr_queue import tcgr_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push_valid,
	output logic       push_ready,
	input  wire cmd_t  push_cmd,
	output logic       head_valid,
	input  wire logic  pop,
	output cmd_t       head_cmd
);

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             ents_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = ents_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			ents_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

// ===== src/tcgr_back.sv =====
// back end: glyph store, row sequencer, read stage and output register
`default_nettype none

module tcgr_back import tcgr_pkg::*; #(
	parameter int unsigned GLYPH_ROWS  = 16,
	parameter int unsigned GLYPH_COLS  = 8,
	parameter int unsigned GLYPH_COUNT = 256
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  head_valid,
	input  wire cmd_t  head_cmd,
	output logic       pop,
	tcgr_out_if.source row_out
);

	localparam int unsigned DEPTH = GLYPH_COUNT * GLYPH_ROWS;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned RCW   = $clog2(GLYPH_ROWS);
	localparam int unsigned SHIFT = FONT_W - GLYPH_COLS;

	logic [FONT_W-1:0] store [DEPTH];

	logic [RCW-1:0]    row_cnt_q;
	logic              last_row;
	logic              wr_en;
	logic              rd_en;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     rd_addr;

	logic              valid_s1;
	logic [FONT_W-1:0] data_s1;
	logic [3:0]        row_s1;
	logic              last_s1;
	logic              overlay_s1;
	rgb_t              fg_s1;
	rgb_t              bg_s1;
	logic              s1_free;

	logic              out_valid_q;
	logic [3:0]        row_q;
	logic [7:0]        pixel_q;
	logic [7:0]        mask_q;
	rgb_t              fg_q;
	rgb_t              bg_q;
	logic              last_q;
	logic              out_free;
	logic [7:0]        pixel_s1;

	assign out_free = !out_valid_q || row_out.ready;
	assign s1_free  = !valid_s1 || out_free;
	assign last_row = (row_cnt_q == RCW'(GLYPH_ROWS - 1));

	// loads write at once, draws read one row per free slot
	assign wr_en = head_valid && !head_cmd.is_draw;
	assign rd_en = head_valid && head_cmd.is_draw && s1_free;
	assign pop   = wr_en || (rd_en && last_row);

	assign wr_addr = AW'(32'(head_cmd.glyph) * 32'(GLYPH_ROWS) + 32'(head_cmd.frow));
	assign rd_addr = AW'(32'(head_cmd.glyph) * 32'(GLYPH_ROWS) + 32'(row_cnt_q));

	// row sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q <= '0;
		end else if (rd_en) begin
			row_cnt_q <= last_row ? '0 : row_cnt_q + 1'b1;
		end
	end

	// glyph store, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store[wr_addr] <= head_cmd.word;
		end
		if (rd_en) begin
			data_s1 <= store[rd_addr];
		end
	end

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= rd_en;
		end
	end

	// read stage row data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			row_s1     <= 4'(row_cnt_q);
			last_s1    <= last_row;
			overlay_s1 <= head_cmd.overlay;
			fg_s1      <= head_cmd.fg;
			bg_s1      <= head_cmd.bg;
		end
	end

	assign pixel_s1 = data_s1[SHIFT +: 8];

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	// output register data
	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			row_q   <= row_s1;
			pixel_q <= pixel_s1;
			mask_q  <= overlay_s1 ? pixel_s1 : MASK_ALL;
			fg_q    <= fg_s1;
			bg_q    <= bg_s1;
			last_q  <= last_s1;
		end
	end

	assign row_out.valid      = out_valid_q;
	assign row_out.row        = row_q;
	assign row_out.pixel_bits = pixel_q;
	assign row_out.write_mask = mask_q;
	assign row_out.fg_rgb     = fg_q;
	assign row_out.bg_rgb     = bg_q;
	assign row_out.last       = last_q;

endmodule

`default_nettype wire

// ===== src/text_cell_glyph_renderer_unit.sv =====
// Text cell glyph renderer, top level.
// cell_in takes items: a load (func low) writes one font word into the glyph
// store at glyph char_code, row font_row; a draw (func high) renders one
// character cell. row_out gives one item per glyph row of a draw, rows 0 up to
// GLYPH_ROWS-1, with last set on the final row; loads give no output.
// cfg_we/cfg_wdata write the mono mode bit, used by draws accepted afterwards.
// The first row of a draw passes through the queue, the glyph store read and
// the output register before it leaves.
// A draw holds the back end for one store read per row, set by the single read
// port of the glyph store; a load takes one write in the back end. Cells follow
// each other with no gap while row_out is not stalled.
// A two entry queue decouples the input from the back end, so items are
// taken while rows of an earlier cell are still going out.
// Reset clears control state and the mode bit; the glyph store is not
// cleared and must be loaded before a glyph is drawn.
// When row_out stalls the output register holds, the read stage and then the
// queue fill, and cell_in.ready falls once the queue is full.
`default_nettype none

module text_cell_glyph_renderer_unit import tcgr_pkg::*; #(
	parameter int unsigned GLYPH_ROWS  = 16,
	parameter int unsigned GLYPH_COLS  = 8,
	parameter int unsigned GLYPH_COUNT = 256
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_we,
	input  wire logic  cfg_wdata,
	tcgr_in_if.sink    cell_in,
	tcgr_out_if.source row_out
);

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic head_valid;
	cmd_t head_cmd;
	logic pop;
	logic mono_mode;

	// classification
	tcgr_front #(
		.GLYPH_ROWS  (GLYPH_ROWS),
		.GLYPH_COUNT (GLYPH_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.cell_in    (cell_in),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.mono_mode  (mono_mode)
	);

	// decoupling queue
	tcgr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.head_valid (head_valid),
		.pop        (pop),
		.head_cmd   (head_cmd)
	);

	// store and row output
	tcgr_back #(
		.GLYPH_ROWS  (GLYPH_ROWS),
		.GLYPH_COLS  (GLYPH_COLS),
		.GLYPH_COUNT (GLYPH_COUNT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.row_out    (row_out)
	);

`ifndef SYNTH
	// the final row of a cell carries the last glyph row index
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		(row_out.valid && row_out.last) |-> (row_out.row == 4'(GLYPH_ROWS - 1)))
		else $error("last flag on wrong row");

	// write mask is either full or exactly the set pixels
	a_mask: assert property (@(posedge clk) disable iff (!arst_n)
		row_out.valid |-> ((row_out.write_mask == MASK_ALL) ||
		(row_out.write_mask == row_out.pixel_bits)))
		else $error("write mask inconsistent with pixel bits");

	// mono mode colors are gray levels
	a_mono_gray: assert property (@(posedge clk) disable iff (!arst_n)
		(row_out.valid && mono_mode && $stable(mono_mode) && $past(mono_mode) &&
		$past(mono_mode, 2) && $past(mono_mode, 3)) |->
		((row_out.fg_rgb[23:16] == row_out.fg_rgb[7:0]) &&
		(row_out.bg_rgb[23:16] == row_out.bg_rgb[7:0])))
		else $error("mono color not gray");
`endif

endmodule

`default_nettype wire

// ===== sim/text_cell_glyph_renderer_unit_check.sv =====
// glyph renderer checker: tracks the font store and mode bit, predicts each row item and compares
`default_nettype none

module text_cell_glyph_renderer_unit_check import tcgr_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_we,
	input  wire logic  cfg_wdata,
	tcgr_in_if         cell_in,
	tcgr_out_if        row_out,
	output int unsigned fail_count,
	output int unsigned rows_pending
);

	localparam int unsigned ROWS_PER_GLYPH = 16;
	localparam int unsigned GLYPHS         = 256;

	// 16 color palette, indexed by the 4 bit color number
	localparam rgb_t PAL_0  = 24'h000000, PAL_1  = 24'h0000C0, PAL_2  = 24'h00C000;
	localparam rgb_t PAL_3  = 24'h00C0C0, PAL_4  = 24'hC00000, PAL_5  = 24'hC000C0;
	localparam rgb_t PAL_6  = 24'hC08000, PAL_7  = 24'hC0C0C0, PAL_8  = 24'h808080;
	localparam rgb_t PAL_9  = 24'h0000FF, PAL_10 = 24'h00FF00, PAL_11 = 24'h00FFFF;
	localparam rgb_t PAL_12 = 24'hFF0000, PAL_13 = 24'hFF00FF, PAL_14 = 24'hFFFF00;
	localparam rgb_t PAL_15 = 24'hFFFFFF;

	typedef struct packed {
		logic [3:0] row;
		logic [7:0] pixel_bits;
		logic [7:0] write_mask;
		rgb_t       fg_rgb;
		rgb_t       bg_rgb;
		logic       last;
	} glyph_row_t;

	logic [15:0] font_mem [GLYPHS*ROWS_PER_GLYPH];
	glyph_row_t  rows_due [$];
	logic        mono;

	function automatic rgb_t palette_rgb(input logic [3:0] idx);
		case (idx)
			4'd0:    return PAL_0;
			4'd1:    return PAL_1;
			4'd2:    return PAL_2;
			4'd3:    return PAL_3;
			4'd4:    return PAL_4;
			4'd5:    return PAL_5;
			4'd6:    return PAL_6;
			4'd7:    return PAL_7;
			4'd8:    return PAL_8;
			4'd9:    return PAL_9;
			4'd10:   return PAL_10;
			4'd11:   return PAL_11;
			4'd12:   return PAL_12;
			4'd13:   return PAL_13;
			4'd14:   return PAL_14;
			default: return PAL_15;
		endcase
	endfunction

	// foreground and background for one attribute byte in the given mode
	function automatic void attr_colors(input logic m, input logic [7:0] a,
		output rgb_t fg, output rgb_t bg);
		logic [7:0] fl;
		logic [7:0] bl;
		if (m) begin
			if ((a & MDA_CLASS_MASK) == 8'h00) begin
				fl = GRAY_BLACK;
				bl = GRAY_BLACK;
			end else if ((a & MDA_CLASS_MASK) == MDA_REVERSE) begin
				fl = a[ATTR_INTENSE] ? GRAY_DARK : GRAY_BLACK;
				bl = a[ATTR_BG_HI] ? GRAY_BRIGHT : GRAY_NORMAL;
			end else begin
				fl = a[ATTR_INTENSE] ? GRAY_BRIGHT : GRAY_NORMAL;
				bl = GRAY_BLACK;
			end
			fg = {3{fl}};
			bg = {3{bl}};
		end else begin
			fg = palette_rgb({a[3], a[2:0]});
			bg = palette_rgb({1'b0, a[6:4]});
		end
	endfunction

	function automatic int field_mismatch(input string name, input logic [23:0] want,
		input logic [23:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// follow both channels and the mode bit at each edge
	always @(posedge clk or negedge arst_n) begin
		glyph_row_t want;
		rgb_t       fg;
		rgb_t       bg;
		logic [7:0] bits;
		int         errs;
		errs = 0;
		if (!arst_n) begin
			mono = 1'b0;
			rows_due.delete();
			fail_count   <= 0;
			rows_pending <= 0;
		end else begin
			if (cfg_we)
				mono = cfg_wdata;

			// compare a leaving row item with the oldest prediction
			if (row_out.valid && row_out.ready) begin
				if (rows_due.size() == 0) begin
					$error("row item %0d with no draw outstanding", row_out.row);
					errs++;
				end else begin
					want = rows_due.pop_front();
					errs += field_mismatch("row", 24'(want.row), 24'(row_out.row));
					errs += field_mismatch("pixel_bits", 24'(want.pixel_bits),
						24'(row_out.pixel_bits));
					errs += field_mismatch("write_mask", 24'(want.write_mask),
						24'(row_out.write_mask));
					errs += field_mismatch("fg_rgb", want.fg_rgb, row_out.fg_rgb);
					errs += field_mismatch("bg_rgb", want.bg_rgb, row_out.bg_rgb);
					errs += field_mismatch("last", 24'(want.last), 24'(row_out.last));
				end
			end

			// loads update the font copy, draws queue one prediction per row
			if (cell_in.valid && cell_in.ready) begin
				if (cell_in.func == FUNC_LOAD) begin
					font_mem[{cell_in.char_code, cell_in.font_row}] = cell_in.font_word;
				end else begin
					attr_colors(mono, cell_in.attr, fg, bg);
					for (int r = 0; r < ROWS_PER_GLYPH; r++) begin
						bits = font_mem[{cell_in.char_code, 4'(r)}][15:8];
						want.row        = 4'(r);
						want.pixel_bits = bits;
						want.write_mask = cell_in.overlay ? bits : MASK_ALL;
						want.fg_rgb     = fg;
						want.bg_rgb     = bg;
						want.last       = (r == ROWS_PER_GLYPH - 1);
						rows_due.push_back(want);
					end
				end
			end

			fail_count   <= fail_count + errs;
			rows_pending <= rows_due.size();
		end
	end

endmodule

`default_nettype wire

// ===== sim/text_cell_glyph_renderer_unit_test.sv =====
// glyph renderer testbench top: clock, reset, stimulus phases and verdict
`default_nettype none

module text_cell_glyph_renderer_unit_test import tcgr_pkg::*;;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned SETTLE       = 8;
	localparam int unsigned PHASE_ITEMS  = 30;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	int unsigned fail_count;
	int unsigned rows_pending;
	int unsigned cycles;
	int unsigned sent;
	int unsigned in_idle;
	int unsigned out_stall;

	// glyphs whose 16 rows have all been loaded may be drawn
	bit [15:0]   rows_loaded [256];
	bit          drawable [256];
	logic [7:0]  drawable_list [$];

	tcgr_in_if  cell_ch ();
	tcgr_out_if row_ch ();

	text_cell_glyph_renderer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cell_in   (cell_ch),
		.row_out   (row_ch)
	);

	text_cell_glyph_renderer_unit_check check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cell_in      (cell_ch),
		.row_out      (row_ch),
		.fail_count   (fail_count),
		.rows_pending (rows_pending)
	);

	always #1 clk = ~clk;

	// receiver stalls at random
	always @(posedge clk) begin
		row_ch.ready <= (out_stall == 0) || ($urandom_range(99) >= out_stall);
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[text_cell_glyph_renderer_unit] ERROR");
			$finish;
		end
	end

	// present one item, with a random gap first, and wait until it is taken
	task automatic send_cell(input logic f, input logic [7:0] code, input logic [3:0] frow,
		input logic [15:0] word, input logic [7:0] attr, input logic ovl);
		if (in_idle > 0 && $urandom_range(99) < in_idle) begin
			cell_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < in_idle);
		end
		cell_ch.valid     <= 1'b1;
		cell_ch.func      <= f;
		cell_ch.char_code <= code;
		cell_ch.font_row  <= frow;
		cell_ch.font_word <= word;
		cell_ch.attr      <= attr;
		cell_ch.overlay   <= ovl;
		@(posedge clk);
		while (!cell_ch.ready) @(posedge clk);
		if (f == FUNC_LOAD) begin
			rows_loaded[code][frow] = 1'b1;
			if (rows_loaded[code] == 16'hFFFF && !drawable[code]) begin
				drawable[code] = 1'b1;
				drawable_list.push_back(code);
			end
		end
		sent++;
	endtask

	task automatic load_glyph(input logic [7:0] code);
		for (int r = 0; r < 16; r++)
			send_cell(FUNC_LOAD, code, 4'(r), 16'($urandom_range(65535)),
				8'($urandom_range(255)), 1'($urandom_range(1)));
	endtask

	task automatic draw_cell(input logic [7:0] code, input logic [7:0] attr, input logic ovl);
		send_cell(FUNC_DRAW, code, 4'($urandom_range(15)), 16'($urandom_range(65535)),
			attr, ovl);
	endtask

	// mode change only once the block has drained
	task automatic set_mono(input logic m);
		cell_ch.valid <= 1'b0;
		@(posedge clk);
		while (rows_pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// glyph numbers lean toward both ends of the range
	function automatic logic [7:0] pick_code();
		int unsigned r;
		r = $urandom_range(9);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom_range(255));
	endfunction

	// attributes lean toward the monochrome class boundaries
	function automatic logic [7:0] pick_attr();
		if ($urandom_range(3) != 0)
			return 8'($urandom_range(255));
		case ($urandom_range(8))
			0:       return 8'h00;
			1:       return 8'h70;
			2:       return 8'hF8;
			3:       return 8'h78;
			4:       return 8'h80;
			5:       return 8'h07;
			6:       return 8'h0F;
			7:       return 8'h88;
			default: return 8'hFF;
		endcase
	endfunction

	initial begin
		int unsigned roll;
		int unsigned target;
		logic [15:0] word;
		clk               = 1'b0;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = 1'b0;
		cycles            = 0;
		sent              = 0;
		in_idle           = 0;
		out_stall         = 0;
		cell_ch.valid     = 1'b0;
		cell_ch.func      = FUNC_LOAD;
		cell_ch.char_code = 8'h00;
		cell_ch.font_row  = 4'h0;
		cell_ch.font_word = 16'h0000;
		cell_ch.attr      = 8'h00;
		cell_ch.overlay   = 1'b0;
		row_ch.ready      = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: one glyph with all-ones and all-zeros rows, then the color cases
		for (int r = 0; r < 16; r++) begin
			case (r)
				0:       word = 16'hFFFF;
				1:       word = 16'h0000;
				2:       word = 16'h8001;
				3:       word = 16'h7FFE;
				default: word = {8'h01 << r[2:0], 8'(r * 17)};
			endcase
			send_cell(FUNC_LOAD, 8'h00, 4'(r), word, 8'h00, 1'b0);
		end
		draw_cell(8'h00, 8'h00, 1'b0);
		draw_cell(8'h00, 8'hFF, 1'b1);
		draw_cell(8'h00, 8'h0F, 1'b0);
		draw_cell(8'h00, 8'h70, 1'b1);
		set_mono(1'b1);
		draw_cell(8'h00, 8'h00, 1'b0);
		draw_cell(8'h00, 8'h88, 1'b1);
		draw_cell(8'h00, 8'h70, 1'b0);
		draw_cell(8'h00, 8'hF8, 1'b1);
		draw_cell(8'h00, 8'h07, 1'b0);
		draw_cell(8'h00, 8'h0F, 1'b1);

		// random: no idling, sender idle, receiver stalling, both
		for (int p = 0; p < 4; p++) begin
			set_mono(p[0]);
			case (p)
				0: begin in_idle = 0;  out_stall = 0;  end
				1: begin in_idle = 69; out_stall = 0;  end
				2: begin in_idle = 0;  out_stall = 69; end
				default: begin in_idle = 18; out_stall = 18; end
			endcase
			target = sent + PHASE_ITEMS;
			if (p == 0)
				load_glyph(8'hFF);
			while (sent < target) begin
				roll = $urandom_range(99);
				if (roll < 12)
					load_glyph(pick_code());
				else if (roll < 25)
					send_cell(FUNC_LOAD, 8'($urandom_range(255)), 4'($urandom_range(15)),
						16'($urandom_range(65535)), 8'($urandom_range(255)),
						1'($urandom_range(1)));
				else
					draw_cell(drawable_list[$urandom_range(drawable_list.size() - 1)],
						pick_attr(), 1'($urandom_range(1)));
			end
		end

		// drain and give the verdict
		cell_ch.valid <= 1'b0;
		out_stall = 0;
		@(posedge clk);
		while (rows_pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("[text_cell_glyph_renderer_unit] OK");
		else
			$display("[text_cell_glyph_renderer_unit] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
